// ----- rtl/fnpll_pkg.sv -----
package fnpll_pkg;

  localparam int XTAL_W  = 26;
  localparam int FREQ_W  = 30;
  localparam int BAND_W  = 3;
  localparam int DIV_W   = 5;
  localparam int INT_W   = 7;
  localparam int FRAC_W  = 20;

  // max pfd is (2 * crystal) / 4, one bit under the crystal width
  localparam int PFD_W   = XTAL_W - 1;

  localparam int FRAC_BITS_DEF = 19;

  localparam logic [XTAL_W-1:0] XTAL_RESET = XTAL_W'(30000000);

  // band thresholds, exclusive upper edge of each band
  localparam logic [FREQ_W-1:0] THR_BAND1 = FREQ_W'(705000000);
  localparam logic [FREQ_W-1:0] THR_BAND2 = FREQ_W'(525000000);
  localparam logic [FREQ_W-1:0] THR_BAND3 = FREQ_W'(353000000);
  localparam logic [FREQ_W-1:0] THR_BAND4 = FREQ_W'(239000000);
  localparam logic [FREQ_W-1:0] THR_BAND5 = FREQ_W'(177000000);

  localparam logic [BAND_W-1:0] BAND_0 = 3'd0;
  localparam logic [BAND_W-1:0] BAND_1 = 3'd1;
  localparam logic [BAND_W-1:0] BAND_2 = 3'd2;
  localparam logic [BAND_W-1:0] BAND_3 = 3'd3;
  localparam logic [BAND_W-1:0] BAND_4 = 3'd4;
  localparam logic [BAND_W-1:0] BAND_5 = 3'd5;

  localparam logic [DIV_W-1:0] DIV_0 = 5'd4;
  localparam logic [DIV_W-1:0] DIV_1 = 5'd6;
  localparam logic [DIV_W-1:0] DIV_2 = 5'd8;
  localparam logic [DIV_W-1:0] DIV_3 = 5'd12;
  localparam logic [DIV_W-1:0] DIV_4 = 5'd16;
  localparam logic [DIV_W-1:0] DIV_5 = 5'd24;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT for any x below 2^28
  localparam int                RECIP3_W     = 28;
  localparam logic [RECIP3_W-1:0] RECIP3     = 28'hAAAAAAB;
  localparam int                RECIP3_SHIFT = 29;
  localparam int                PROD_W       = XTAL_W + RECIP3_W;

  localparam logic [INT_W-1:0]  INT_MAX   = 7'd127;
  localparam logic [FREQ_W-1:0] WHOLE_MAX = FREQ_W'(128);

  typedef struct packed {
    logic              valid;
    logic [BAND_W-1:0] band;
    logic [DIV_W-1:0]  div;
    logic              zero;
  } side_t;

endpackage

// ----- rtl/fractional_n_pll_word_calc_top.sv -----
// Fractional-N synthesizer word calculator.
// Command channel: drive target_freq_hz_i and pulse start; the word is taken at
// each clock edge where start is high and busy is low. busy never rises, so a
// new word can be issued every cycle (one word per cycle sustained).
// Result channel: result_valid_o is high for exactly one cycle carrying band,
// output divider, integer word, fractional word and the range error flag.
// Results come out in issue order; the receiver cannot stall, so sample them
// in the strobe cycle.
// Pipeline: two front stages form the phase-detector frequency, one divider
// cell per quotient bit (30 + FRAC_BITS cells) resolves the quotient, and one
// output stage saturates and registers the words.
// Configuration: write cfg_wdata_i (crystal frequency in Hz) with cfg_we_i
// while no word is in flight; the next issued word uses the new value.
// Reset: rst_ni clears every valid bit in the chain, so words in flight are
// dropped, and the crystal register returns to 30 MHz.
module fractional_n_pll_word_calc_top #(
  parameter int FRAC_BITS = fnpll_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [fnpll_pkg::FREQ_W-1:0]  target_freq_hz_i,
  input  logic                          cfg_we_i,
  input  logic [fnpll_pkg::XTAL_W-1:0]  cfg_wdata_i,
  output logic                          result_valid_o,
  output logic [fnpll_pkg::BAND_W-1:0]  band_code_o,
  output logic [fnpll_pkg::DIV_W-1:0]   output_divider_o,
  output logic [fnpll_pkg::INT_W-1:0]   pll_integer_o,
  output logic [fnpll_pkg::FRAC_W-1:0]  pll_fraction_o,
  output logic                          range_error_o
);

  // one cell per quotient bit of (freq << FRAC_BITS) / pfd
  localparam int NW = fnpll_pkg::FREQ_W + FRAC_BITS;

  logic [fnpll_pkg::XTAL_W-1:0] xtal_q;

  fnpll_pkg::side_t             side [NW+1];
  logic [fnpll_pkg::PFD_W-1:0]  rem  [NW+1];
  logic [NW-1:0]                nq   [NW+1];
  logic [fnpll_pkg::PFD_W-1:0]  dvs  [NW+1];

  // the chain is fully pipelined: never hold off a command
  assign busy = 1'b0;

  // crystal frequency register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xtal_q <= fnpll_pkg::XTAL_RESET;
    end else if (cfg_we_i) begin
      xtal_q <= cfg_wdata_i;
    end
  end

  // band select and phase-detector frequency
  fnpll_front #(
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (start && !busy),
    .freq_i   (target_freq_hz_i),
    .xtal_i   (xtal_q),
    .side_o   (side[0]),
    .rem_o    (rem[0]),
    .nq_o     (nq[0]),
    .d_o      (dvs[0])
  );

  // restoring divider: each cell resolves one quotient bit and hands on
  // remainder, shifting dividend/quotient word and divisor
  for (genvar i = 0; i < NW; i++) begin : g_cell
    fnpll_div_cell #(
      .NW (NW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .side_i (side[i]),
      .rem_i  (rem[i]),
      .nq_i   (nq[i]),
      .d_i    (dvs[i]),
      .side_o (side[i+1]),
      .rem_o  (rem[i+1]),
      .nq_o   (nq[i+1]),
      .d_o    (dvs[i+1])
    );
  end

  // saturate the integer word, form the fractional word, register results
  fnpll_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .side_i  (side[NW]),
    .q_i     (nq[NW]),
    .valid_o (result_valid_o),
    .band_o  (band_code_o),
    .div_o   (output_divider_o),
    .int_o   (pll_integer_o),
    .frac_o  (pll_fraction_o),
    .err_o   (range_error_o)
  );

endmodule

// ----- rtl/fnpll_front.sv -----
module fnpll_front #(
  parameter int FRAC_BITS = fnpll_pkg::FRAC_BITS_DEF,
  localparam int NW       = fnpll_pkg::FREQ_W + FRAC_BITS
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             accept_i,
  input  logic [fnpll_pkg::FREQ_W-1:0]     freq_i,
  input  logic [fnpll_pkg::XTAL_W-1:0]     xtal_i,
  output fnpll_pkg::side_t                 side_o,
  output logic [fnpll_pkg::PFD_W-1:0]      rem_o,
  output logic [NW-1:0]                    nq_o,
  output logic [fnpll_pkg::PFD_W-1:0]      d_o
);

  logic                          v0_q;
  logic [fnpll_pkg::FREQ_W-1:0]  freq0_q;

  logic [fnpll_pkg::BAND_W-1:0]  band;
  logic [fnpll_pkg::DIV_W-1:0]   div;
  logic [2:0]                    sh;
  logic                          by3;
  logic [fnpll_pkg::XTAL_W:0]    two_x;
  logic [fnpll_pkg::XTAL_W-1:0]  x;
  logic [fnpll_pkg::PROD_W-1:0]  prod;

  logic                          v1_q;
  logic [fnpll_pkg::BAND_W-1:0]  band1_q;
  logic [fnpll_pkg::DIV_W-1:0]   div1_q;
  logic                          by3_q;
  logic [fnpll_pkg::XTAL_W-1:0]  x1_q;
  logic [fnpll_pkg::PROD_W-1:0]  prod_q;
  logic [fnpll_pkg::FREQ_W-1:0]  freq1_q;
  logic [fnpll_pkg::PFD_W-1:0]   pfd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
    end else begin
      v0_q <= accept_i;
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      freq0_q <= freq_i;
    end
    band1_q <= band;
    div1_q  <= div;
    by3_q   <= by3;
    x1_q    <= x;
    prod_q  <= prod;
    freq1_q <= freq0_q;
  end

  // pick band by threshold, then split the divider into a shift and an optional /3
  always_comb begin
    band = fnpll_pkg::BAND_0;
    if (freq0_q < fnpll_pkg::THR_BAND1) band = fnpll_pkg::BAND_1;
    if (freq0_q < fnpll_pkg::THR_BAND2) band = fnpll_pkg::BAND_2;
    if (freq0_q < fnpll_pkg::THR_BAND3) band = fnpll_pkg::BAND_3;
    if (freq0_q < fnpll_pkg::THR_BAND4) band = fnpll_pkg::BAND_4;
    if (freq0_q < fnpll_pkg::THR_BAND5) band = fnpll_pkg::BAND_5;
  end

  always_comb begin
    case (band)
      fnpll_pkg::BAND_1: begin div = fnpll_pkg::DIV_1; sh = 3'd1; by3 = 1'b1; end
      fnpll_pkg::BAND_2: begin div = fnpll_pkg::DIV_2; sh = 3'd3; by3 = 1'b0; end
      fnpll_pkg::BAND_3: begin div = fnpll_pkg::DIV_3; sh = 3'd2; by3 = 1'b1; end
      fnpll_pkg::BAND_4: begin div = fnpll_pkg::DIV_4; sh = 3'd4; by3 = 1'b0; end
      fnpll_pkg::BAND_5: begin div = fnpll_pkg::DIV_5; sh = 3'd3; by3 = 1'b1; end
      default:           begin div = fnpll_pkg::DIV_0; sh = 3'd2; by3 = 1'b0; end
    endcase
  end

  assign two_x = {xtal_i, 1'b0};
  assign x     = fnpll_pkg::XTAL_W'(two_x >> sh);
  assign prod  = fnpll_pkg::PROD_W'(x) * fnpll_pkg::PROD_W'(fnpll_pkg::RECIP3);

  assign pfd = by3_q ? prod_q[fnpll_pkg::RECIP3_SHIFT +: fnpll_pkg::PFD_W]
                     : x1_q[fnpll_pkg::PFD_W-1:0];

  always_comb begin
    side_o.valid = v1_q;
    side_o.band  = band1_q;
    side_o.div   = div1_q;
    side_o.zero  = (pfd == '0);
  end

  assign rem_o = '0;
  assign nq_o  = {freq1_q, {FRAC_BITS{1'b0}}};
  assign d_o   = pfd;

endmodule

// ----- rtl/fnpll_div_cell.sv -----
module fnpll_div_cell #(
  parameter int NW = fnpll_pkg::FREQ_W + fnpll_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fnpll_pkg::side_t             side_i,
  input  logic [fnpll_pkg::PFD_W-1:0]  rem_i,
  input  logic [NW-1:0]                nq_i,
  input  logic [fnpll_pkg::PFD_W-1:0]  d_i,
  output fnpll_pkg::side_t             side_o,
  output logic [fnpll_pkg::PFD_W-1:0]  rem_o,
  output logic [NW-1:0]                nq_o,
  output logic [fnpll_pkg::PFD_W-1:0]  d_o
);

  logic [fnpll_pkg::PFD_W:0]    rem_sh;
  logic                         ge;
  logic [fnpll_pkg::PFD_W:0]    diff;
  fnpll_pkg::side_t             side_q;
  logic [fnpll_pkg::PFD_W-1:0]  rem_q;
  logic [NW-1:0]                nq_q;
  logic [fnpll_pkg::PFD_W-1:0]  d_q;

  // shift in the next dividend bit, subtract when it fits
  assign rem_sh = {rem_i, nq_i[NW-1]};
  assign ge     = rem_sh >= {1'b0, d_i};
  assign diff   = rem_sh - {1'b0, d_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      side_q <= '0;
    end else begin
      side_q <= side_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= ge ? diff[fnpll_pkg::PFD_W-1:0] : rem_sh[fnpll_pkg::PFD_W-1:0];
    nq_q  <= {nq_i[NW-2:0], ge};
    d_q   <= d_i;
  end

  assign side_o = side_q;
  assign rem_o  = rem_q;
  assign nq_o   = nq_q;
  assign d_o    = d_q;

endmodule

// ----- rtl/fnpll_back.sv -----
module fnpll_back #(
  parameter int FRAC_BITS = fnpll_pkg::FRAC_BITS_DEF,
  localparam int NW       = fnpll_pkg::FREQ_W + FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  fnpll_pkg::side_t              side_i,
  input  logic [NW-1:0]                 q_i,
  output logic                          valid_o,
  output logic [fnpll_pkg::BAND_W-1:0]  band_o,
  output logic [fnpll_pkg::DIV_W-1:0]   div_o,
  output logic [fnpll_pkg::INT_W-1:0]   int_o,
  output logic [fnpll_pkg::FRAC_W-1:0]  frac_o,
  output logic                          err_o
);

  logic [fnpll_pkg::FREQ_W-1:0]  whole;
  logic [FRAC_BITS:0]            frac_full;
  logic [fnpll_pkg::FREQ_W-1:0]  whole_m1;
  logic [fnpll_pkg::INT_W-1:0]   int_d;
  logic [fnpll_pkg::FRAC_W-1:0]  frac_d;
  logic                          err_d;
  logic                          valid_q;
  logic [fnpll_pkg::BAND_W-1:0]  band_q;
  logic [fnpll_pkg::DIV_W-1:0]   div_q;
  logic [fnpll_pkg::INT_W-1:0]   int_q;
  logic [fnpll_pkg::FRAC_W-1:0]  frac_q;
  logic                          err_q;

  assign whole     = q_i[NW-1:FRAC_BITS];
  assign whole_m1  = whole - fnpll_pkg::FREQ_W'(1);
  assign frac_full = {1'b1, q_i[FRAC_BITS-1:0]};

  always_comb begin
    frac_d = fnpll_pkg::FRAC_W'(frac_full);
    if (side_i.zero) begin
      int_d  = fnpll_pkg::INT_MAX;
      frac_d = '0;
      err_d  = 1'b1;
    end else if (whole == '0) begin
      int_d = '0;
      err_d = 1'b1;
    end else if (whole > fnpll_pkg::WHOLE_MAX) begin
      int_d = fnpll_pkg::INT_MAX;
      err_d = 1'b1;
    end else begin
      int_d = whole_m1[fnpll_pkg::INT_W-1:0];
      err_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= side_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    band_q <= side_i.band;
    div_q  <= side_i.div;
    int_q  <= int_d;
    frac_q <= frac_d;
    err_q  <= err_d;
  end

  assign valid_o = valid_q;
  assign band_o  = band_q;
  assign div_o   = div_q;
  assign int_o   = int_q;
  assign frac_o  = frac_q;
  assign err_o   = err_q;

endmodule

// ----- rtl/fnpll_chk.sv -----
module fnpll_chk #(
  parameter int FRAC_BITS = fnpll_pkg::FRAC_BITS_DEF,
  localparam int LAT      = fnpll_pkg::FREQ_W + FRAC_BITS + 3
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          start,
  input logic                          result_valid_o,
  input logic [fnpll_pkg::BAND_W-1:0]  band_code_o,
  input logic [fnpll_pkg::DIV_W-1:0]   output_divider_o,
  input logic [fnpll_pkg::INT_W-1:0]   pll_integer_o,
  input logic [fnpll_pkg::FRAC_W-1:0]  pll_fraction_o,
  input logic                          range_error_o
);

  // a result only follows a command issued exactly one latency earlier
  a_result_has_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LAT))
    else $error("result without matching command");

  a_band_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> band_code_o <= fnpll_pkg::BAND_5)
    else $error("band code out of range");

  a_div_matches_band: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      (band_code_o == fnpll_pkg::BAND_0 && output_divider_o == fnpll_pkg::DIV_0) ||
      (band_code_o == fnpll_pkg::BAND_1 && output_divider_o == fnpll_pkg::DIV_1) ||
      (band_code_o == fnpll_pkg::BAND_2 && output_divider_o == fnpll_pkg::DIV_2) ||
      (band_code_o == fnpll_pkg::BAND_3 && output_divider_o == fnpll_pkg::DIV_3) ||
      (band_code_o == fnpll_pkg::BAND_4 && output_divider_o == fnpll_pkg::DIV_4) ||
      (band_code_o == fnpll_pkg::BAND_5 && output_divider_o == fnpll_pkg::DIV_5))
    else $error("output divider does not match band");

  // fractional word carries its implicit one unless the zero-pfd case hit
  a_frac_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (FRAC_BITS < fnpll_pkg::FRAC_W) &&
    !(range_error_o && pll_integer_o == fnpll_pkg::INT_MAX && pll_fraction_o == '0)
    |-> (pll_fraction_o >> FRAC_BITS) != '0)
    else $error("fractional word lost its offset");

endmodule

bind fractional_n_pll_word_calc_top fnpll_chk #(
  .FRAC_BITS (FRAC_BITS)
) u_fnpll_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .result_valid_o   (result_valid_o),
  .band_code_o      (band_code_o),
  .output_divider_o (output_divider_o),
  .pll_integer_o    (pll_integer_o),
  .pll_fraction_o   (pll_fraction_o),
  .range_error_o    (range_error_o)
);
